[rtl/tpps_pkg.sv]
package tpps_pkg;

  localparam int CLK_W    = 28;
  localparam int FREQ_W   = 16;
  localparam int PRESC_W  = 11;
  localparam int PERIOD_W = 16;

  // shared divider: dividend holds the clock or the count, divisor a frequency or a prescale
  localparam int DVD_W = 28;
  localparam int DVS_W = 16;

  localparam logic [CLK_W-1:0] CLK_RESET    = 28'd72000000;
  localparam logic [DVS_W-1:0] ROUND_LIMIT  = 16'd32768;
  localparam logic [DVD_W-1:0] PERIOD_LIMIT = 28'd65535;

  localparam int MAX_PRESCALE_DEF = 1200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_CLK,
    ST_START,
    ST_WAIT_CAND,
    ST_DONE
  } tpps_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/tpps_div.sv]
module tpps_div
  import tpps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] quo_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !ctl.start && (cnt_r == CNT_LAST);
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/tpps_ctrl.sv]
module tpps_ctrl
  import tpps_pkg::*;
#(
  parameter int MAX_PRESCALE = MAX_PRESCALE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CLK_W-1:0]    source_clock_hz,
  input  logic                in_valid,
  input  logic [FREQ_W-1:0]   in_frequency_hz,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PRESC_W-1:0]  out_prescale,
  output logic [PERIOD_W-1:0] out_period,
  output logic                out_exact_divisor,
  output logic                out_found,
  output div_ctl_t            div_ctl,
  input  div_sts_t            div_sts,
  output logic [DVD_W-1:0]    div_dividend,
  output logic [DVS_W-1:0]    div_divisor,
  input  logic [DVD_W-1:0]    div_quotient,
  input  logic [DVS_W-1:0]    div_remainder
);

  localparam int CW = $clog2(MAX_PRESCALE + 1);
  localparam logic [CW-1:0] CAND_LAST = CW'(MAX_PRESCALE);

  tpps_state_t state_r, state_nxt;

  logic [CW-1:0]       cand_r, cand_nxt;
  logic [DVD_W-1:0]    count_r, count_nxt;
  logic                res_found_r, res_found_nxt;
  logic [CW-1:0]       res_presc_r, res_presc_nxt;
  logic [PERIOD_W-1:0] res_period_r, res_period_nxt;
  logic                res_exact_r, res_exact_nxt;

  logic                in_xfer;
  logic                q_fits;
  logic                exact;
  logic [DVS_W-1:0]    presc_ext;

  assign in_xfer = in_valid && !in_stall;
  assign q_fits  = (div_quotient < PERIOD_LIMIT);
  assign exact   = q_fits && (div_remainder == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_frequency_hz == '0) ? ST_DONE : ST_WAIT_CLK;
        end
      end
      ST_WAIT_CLK: begin
        if (div_sts.done) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_WAIT_CAND;
      end
      ST_WAIT_CAND: begin
        if (div_sts.done) begin
          state_nxt = (exact || cand_r == CAND_LAST) ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    div_ctl.start = 1'b0;
    div_dividend  = count_r;
    div_divisor   = DVS_W'(cand_r);
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        div_ctl.start = in_valid && (in_frequency_hz != '0);
        div_dividend  = DVD_W'(source_clock_hz);
        div_divisor   = DVS_W'(in_frequency_hz);
      end
      ST_START: begin
        div_ctl.start = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // search bookkeeping: keep the first fitting prescale, replace it by an exact one
  always_comb begin
    cand_nxt       = cand_r;
    count_nxt      = count_r;
    res_found_nxt  = res_found_r;
    res_presc_nxt  = res_presc_r;
    res_period_nxt = res_period_r;
    res_exact_nxt  = res_exact_r;
    if (state_r == ST_IDLE && in_xfer) begin
      res_found_nxt  = 1'b0;
      res_presc_nxt  = '0;
      res_period_nxt = '0;
      res_exact_nxt  = 1'b0;
    end
    if (state_r == ST_WAIT_CLK && div_sts.done) begin
      count_nxt = div_quotient + DVD_W'(div_remainder > ROUND_LIMIT);
      cand_nxt  = CW'(1);
    end
    if (state_r == ST_WAIT_CAND && div_sts.done) begin
      if (exact || (q_fits && !res_found_r)) begin
        res_found_nxt  = 1'b1;
        res_presc_nxt  = cand_r;
        res_period_nxt = div_quotient[PERIOD_W-1:0];
        res_exact_nxt  = exact;
      end
      if (cand_r != CAND_LAST) cand_nxt = cand_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    count_r      <= count_nxt;
    res_found_r  <= res_found_nxt;
    res_presc_r  <= res_presc_nxt;
    res_period_r <= res_period_nxt;
    res_exact_r  <= res_exact_nxt;
  end

  assign presc_ext         = DVS_W'(res_presc_r);
  assign out_prescale      = presc_ext[PRESC_W-1:0];
  assign out_period        = res_period_r;
  assign out_exact_divisor = res_exact_r;
  assign out_found         = res_found_r;

endmodule

[rtl/timer_prescale_period_search.sv]
// channel   direction  handshake                 payload
// in        input      in_valid / in_stall       in_frequency_hz[15:0]
// out       output     out_valid / out_stall     out_prescale[10:0], out_period[15:0],
//                                                out_exact_divisor, out_found
// cfg       input      cfg_wr_en                 cfg_wr_data[27:0] (source_clock_hz)
//
// one item at a time: a single restoring divider is shared by every division
// the clock is divided by the frequency first, then the resulting count by each prescale candidate
// in the worst case every prescale from 1 to MAX_PRESCALE is tried (1200 by default)
// a zero frequency gives an all-zero result in the cycle after its transfer
// rst_n is synchronous; the clock register resets to 72000000
// in_stall stays high from the input transfer until the result transfer
module timer_prescale_period_search
  import tpps_pkg::*;
#(
  parameter int MAX_PRESCALE = MAX_PRESCALE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CLK_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FREQ_W-1:0]   in_frequency_hz,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PRESC_W-1:0]  out_prescale,
  output logic [PERIOD_W-1:0] out_period,
  output logic                out_exact_divisor,
  output logic                out_found
);

  logic [CLK_W-1:0] clk_hz_r;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quotient;
  logic [DVS_W-1:0] div_remainder;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  tpps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  tpps_ctrl #(
    .MAX_PRESCALE (MAX_PRESCALE)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .source_clock_hz   (clk_hz_r),
    .in_valid          (in_valid),
    .in_frequency_hz   (in_frequency_hz),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prescale      (out_prescale),
    .out_period        (out_period),
    .out_exact_divisor (out_exact_divisor),
    .out_found         (out_found),
    .div_ctl           (div_ctl),
    .div_sts           (div_sts),
    .div_dividend      (div_dividend),
    .div_divisor       (div_divisor),
    .div_quotient      (div_quotient),
    .div_remainder     (div_remainder)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_prescale == '0 && out_period == '0 &&
                                   !out_exact_divisor))
    else $error("result without a prescale is not all zero");

  a_exact_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_exact_divisor) |-> out_found)
    else $error("exact flag without a found prescale");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

endmodule
